@@ rtl/core/gnfa_pkg.sv @@
// Package for the grouped next-fit bitmap allocator.
// Transfer payload types, field widths, operation and status codes, table update struct.
// No dependencies.
package gnfa_pkg;

   localparam int UNIT_W    = 12;
   localparam int GCOUNT_W  = 5;
   localparam int LGU_W     = 9;
   localparam int CSR_W     = 9;
   localparam int STATUS_W  = 2;
   localparam int UPD_GRP_W = 8;
   localparam int UPD_CNT_W = 17;
   localparam int UPD_POS_W = 16;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic CSR_GROUP_COUNT = 1'b0;
   localparam logic CSR_LAST_UNITS  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   typedef struct packed {
      logic              action;
      logic [UNIT_W-1:0] unit_number;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [UNIT_W-1:0]   allocated_unit;
   } rsp_payload_type;

   typedef struct packed {
      logic                 cnt_we;
      logic                 pos_we;
      logic [UPD_GRP_W-1:0] grp;
      logic [UPD_CNT_W-1:0] cnt;
      logic [UPD_POS_W-1:0] pos;
   } grp_upd_type;

endpackage

@@ rtl/core/gnfa_bitmap_ram.sv @@
// Bitmap word memory with a registered read port and one write port.
// Per-word valid bits make unwritten words read as zero after a clear. Uses gnfa_pkg.
module gnfa_bitmap_ram
   import gnfa_pkg::*;
#(
   parameter int DEPTH     = 128,
   parameter int WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_BITS-1:0]     rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]     wr_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]     vld_ff;
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 rvld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         rvld_ff <= vld_ff[rd_addr];
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rvld_ff ? rdata_ff : '0;

endmodule

@@ rtl/core/gnfa_group_table.sv @@
// Per-group free count and next-fit position.
// Reinitialized from the group configuration on init. Uses gnfa_pkg.
module gnfa_group_table
   import gnfa_pkg::*;
#(
   parameter int GROUPS          = 16,
   parameter int UNITS_PER_GROUP = 256
) (
   input  logic                                    clock,
   input  logic                                    init,
   input  logic [GCOUNT_W-1:0]                     group_count,
   input  logic [LGU_W-1:0]                        last_units,
   input  logic [(GROUPS > 1 ? $clog2(GROUPS) : 1)-1:0] rd_grp,
   output logic [$clog2(UNITS_PER_GROUP+1)-1:0]    rd_cnt,
   output logic [$clog2(UNITS_PER_GROUP)-1:0]      rd_pos,
   input  grp_upd_type                             upd
);

   localparam int GW  = GROUPS > 1 ? $clog2(GROUPS) : 1;
   localparam int SZW = $clog2(UNITS_PER_GROUP + 1);
   localparam int PW  = $clog2(UNITS_PER_GROUP);
   localparam int CW  = (GW > GCOUNT_W ? GW : GCOUNT_W) + 1;
   localparam int LW  = SZW > LGU_W ? SZW : LGU_W;

   logic [SZW-1:0] cnt_ff [GROUPS];
   logic [PW-1:0]  pos_ff [GROUPS];
   logic [GW-1:0]  ugrp;

   assign ugrp   = GW'(upd.grp);
   assign rd_cnt = cnt_ff[rd_grp];
   assign rd_pos = pos_ff[rd_grp];

   always_ff @(posedge clock) begin
      if (init) begin
         for (int g = 0; g < GROUPS; g++) begin
            if (CW'(g) >= CW'(group_count)) begin
               cnt_ff[g] <= '0;
            end else if (CW'(g) + CW'(1) == CW'(group_count)) begin
               cnt_ff[g] <= SZW'(LW'(last_units));
            end else begin
               cnt_ff[g] <= SZW'(UNITS_PER_GROUP);
            end
            pos_ff[g] <= '0;
         end
      end else begin
         if (upd.cnt_we) begin
            cnt_ff[ugrp] <= SZW'(upd.cnt);
         end
         if (upd.pos_we) begin
            pos_ff[ugrp] <= PW'(upd.pos);
         end
      end
   end

endmodule

@@ rtl/core/grouped_next_fit_bitmap_allocator_top.sv @@
// Top level of the grouped next-fit bitmap allocator: sequencer and registers.
// Uses gnfa_pkg, gnfa_bitmap_ram and gnfa_group_table.
//
// Usage: each req transfer (action, unit_number) yields exactly one rsp transfer
// (status, allocated_unit), in order. req_stall is high while a request is in
// progress; one request is worked on at a time.
// Free: range check, word read, then write, before the result register; an
// out-of-range unit goes from the range check straight to the result.
// Allocate: a table check per group visited plus a read and a check per bitmap
// word, then the result hand-over; a group with zero free count costs only its
// table check. The single bitmap memory port sets the scan speed.
// The result sits in an output register; a new request is accepted while it waits
// for the receiver. If rsp_stall holds it, the next finished result waits inside
// the sequencer until the register frees up.
// csr writes (group_count, last_group_units) are taken at any edge with csr_write;
// values saturate into range and the whole store is reinitialized.
// Reset is synchronous. After reset and after each csr write, reinitialization
// runs with req_stall high; current group returns to 0.
module grouped_next_fit_bitmap_allocator_top
   import gnfa_pkg::*;
#(
   parameter int GROUPS          = 16,
   parameter int UNITS_PER_GROUP = 256,
   parameter int WORD_BITS       = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write,
   input  logic            csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int WPG   = (UNITS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH = GROUPS * WPG;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int GW    = GROUPS > 1 ? $clog2(GROUPS) : 1;
   localparam int WIW   = WPG > 1 ? $clog2(WPG) : 1;
   localparam int JW    = $clog2(WORD_BITS);
   localparam int SZW   = $clog2(UNITS_PER_GROUP + 1);
   localparam int PW    = $clog2(UNITS_PER_GROUP);
   localparam int EW    = $clog2(UNITS_PER_GROUP + WORD_BITS);
   localparam int CW    = (GW > GCOUNT_W ? GW : GCOUNT_W) + 1;
   localparam int LW    = (SZW > LGU_W ? SZW : LGU_W) + 1;
   localparam int BW    = SZW > UNIT_W ? SZW : UNIT_W;
   localparam int UW    = (GW + SZW > UNIT_W) ? GW + SZW : UNIT_W;
   localparam int GC_RST  = GROUPS < 16 ? GROUPS : 16;
   localparam int LGU_RST = UNITS_PER_GROUP < 256 ? UNITS_PER_GROUP : 256;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_GRP  = 6'b000010,
      S_FREE = 6'b000100,
      S_RD   = 6'b001000,
      S_CHK  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic                reinit_ff;
   logic [GCOUNT_W-1:0] gc_ff;
   logic [LGU_W-1:0]    lgu_ff;
   logic [GW-1:0]       cur_ff, cur_in, start_ff, start_in, fgrp_ff, fgrp_in;
   logic                retry_ff, retry_in;
   logic                act_ff, act_in;
   logic [UNIT_W-1:0]   unit_ff, unit_in;
   logic [WIW-1:0]      word_ff, word_in;
   logic [JW-1:0]       fbit_ff, fbit_in;
   rsp_payload_type     res_ff, res_in;
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_ff;

   logic [GW-1:0]          tbl_grp, nxt_grp;
   logic [SZW-1:0]         rd_cnt, size_cur, size_f;
   logic [PW-1:0]          rd_pos, found_b;
   grp_upd_type            upd;
   logic [AW-1:0]          mem_addr;
   logic [WORD_BITS-1:0]   rd_data, wr_data;
   logic                   wr_en;
   logic [EW-1:0]          base;
   logic [EW:0]            next_base;
   logic [WORD_BITS-1:0]   avail;
   logic                   hit;
   logic [JW-1:0]          jsel;
   logic                   fail_grp;
   logic [UNIT_W-1:0]      fg_full;
   logic [BW-1:0]          fb_full;
   logic                   f_range_bad;
   logic [UW-1:0]          given;
   logic                   out_free;
   logic [LW-1:0]          lgu_cand;
   logic [CW-1:0]          gc_cand;

   function automatic logic [SZW-1:0] gsize(input logic [GW-1:0] g,
                                            input logic [GCOUNT_W-1:0] gc,
                                            input logic [LGU_W-1:0] lgu);
      logic [SZW-1:0] s;
      if (CW'(g) >= CW'(gc)) begin
         s = '0;
      end else if (CW'(g) + CW'(1) == CW'(gc)) begin
         s = SZW'(lgu);
      end else begin
         s = SZW'(UNITS_PER_GROUP);
      end
      return s;
   endfunction

   gnfa_bitmap_ram #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (reinit_ff),
      .rd_addr (mem_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (mem_addr),
      .wr_data (wr_data)
   );

   gnfa_group_table #(
      .GROUPS          (GROUPS),
      .UNITS_PER_GROUP (UNITS_PER_GROUP)
   ) u_table (
      .clock       (clock),
      .init        (reinit_ff),
      .group_count (gc_ff),
      .last_units  (lgu_ff),
      .rd_grp      (tbl_grp),
      .rd_cnt      (rd_cnt),
      .rd_pos      (rd_pos),
      .upd         (upd)
   );

   assign tbl_grp  = (act_ff == ACT_FREE) ? fgrp_ff : cur_ff;
   assign mem_addr = AW'(tbl_grp) * AW'(WPG) + AW'(word_ff);
   assign size_cur = gsize(cur_ff, gc_ff, lgu_ff);

   // free target decode
   assign fg_full     = UNIT_W'(unit_ff / UNITS_PER_GROUP);
   assign fb_full     = BW'(unit_ff % UNITS_PER_GROUP);
   assign size_f      = gsize(GW'(fg_full), gc_ff, lgu_ff);
   assign f_range_bad = (CW'(fg_full) >= CW'(gc_ff)) || (fb_full >= BW'(size_f));

   // scan of the current word
   assign base      = EW'(word_ff) * EW'(WORD_BITS);
   assign next_base = (EW + 1)'(base) + (EW + 1)'(WORD_BITS);

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         avail[j] = !rd_data[j] && (base + EW'(j) >= EW'(rd_pos))
                    && (base + EW'(j) < EW'(size_cur));
      end
   end

   always_comb begin
      hit  = 1'b0;
      jsel = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (avail[j]) begin
            hit  = 1'b1;
            jsel = JW'(j);
         end
      end
   end

   assign found_b = PW'(base + EW'(jsel));
   assign given   = UW'(cur_ff) * UW'(UNITS_PER_GROUP) + UW'(found_b);
   assign nxt_grp = (CW'(cur_ff) + CW'(1) == CW'(gc_ff)) ? '0 : GW'(CW'(cur_ff) + CW'(1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      start_in = start_ff;
      retry_in = retry_ff;
      act_in   = act_ff;
      unit_in  = unit_ff;
      word_in  = word_ff;
      fbit_in  = fbit_ff;
      fgrp_in  = fgrp_ff;
      res_in   = res_ff;
      upd      = '0;
      upd.grp  = UPD_GRP_W'(tbl_grp);
      wr_en    = 1'b0;
      wr_data  = rd_data;
      fail_grp = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !reinit_ff) begin
               act_in   = req_payload.action;
               unit_in  = req_payload.unit_number;
               start_in = cur_ff;
               retry_in = 1'b0;
               state_in = (req_payload.action == ACT_FREE) ? S_FREE : S_GRP;
            end
         end
         S_GRP: begin
            if (rd_cnt == '0) begin
               fail_grp = 1'b1;
            end else if (SZW'(rd_pos) >= size_cur) begin
               upd.pos_we = 1'b1;
               fail_grp   = 1'b1;
            end else begin
               word_in  = WIW'(rd_pos / WORD_BITS);
               state_in = S_RD;
            end
         end
         S_FREE: begin
            if (f_range_bad) begin
               res_in.status         = ST_RANGE;
               res_in.allocated_unit = '0;
               state_in              = S_DONE;
            end else begin
               fgrp_in  = GW'(fg_full);
               word_in  = WIW'(fb_full / WORD_BITS);
               fbit_in  = JW'(fb_full % WORD_BITS);
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (act_ff == ACT_FREE) begin
               if (rd_data[fbit_ff]) begin
                  wr_en   = 1'b1;
                  wr_data = rd_data & ~(WORD_BITS'(1) << fbit_ff);
                  upd.cnt_we = 1'b1;
                  upd.cnt    = UPD_CNT_W'(rd_cnt) + UPD_CNT_W'(1);
               end
               res_in.status         = ST_OK;
               res_in.allocated_unit = '0;
               state_in              = S_DONE;
            end else if (hit) begin
               wr_en      = 1'b1;
               wr_data    = rd_data | (WORD_BITS'(1) << jsel);
               upd.cnt_we = 1'b1;
               upd.cnt    = UPD_CNT_W'(rd_cnt - SZW'(1));
               upd.pos_we = 1'b1;
               upd.pos    = UPD_POS_W'(found_b);
               res_in.status         = ST_OK;
               res_in.allocated_unit = UNIT_W'(given);
               state_in              = S_DONE;
            end else if (next_base >= (EW + 1)'(size_cur)) begin
               upd.pos_we = 1'b1;
               fail_grp   = 1'b1;
            end else begin
               word_in  = word_ff + WIW'(1);
               state_in = S_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (fail_grp) begin
         if (retry_ff) begin
            res_in.status         = ST_NO_SPACE;
            res_in.allocated_unit = '0;
            state_in              = S_DONE;
         end else begin
            cur_in   = nxt_grp;
            state_in = S_GRP;
            if (nxt_grp == start_ff) begin
               retry_in = 1'b1;
            end
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE) || reinit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reinit_ff    <= 1'b1;
         gc_ff        <= GCOUNT_W'(GC_RST);
         lgu_ff       <= LGU_W'(LGU_RST);
         cur_ff       <= '0;
         retry_ff     <= 1'b0;
         act_ff       <= ACT_ALLOC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         retry_ff  <= retry_in;
         act_ff    <= act_in;
         reinit_ff <= csr_write;
         cur_ff    <= reinit_ff ? '0 : cur_in;
         if (csr_write) begin
            if (csr_index == CSR_GROUP_COUNT) begin
               gc_ff <= GCOUNT_W'(gc_cand);
            end else begin
               lgu_ff <= LGU_W'(lgu_cand);
            end
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      gc_cand = CW'(csr_wdata[GCOUNT_W-1:0]);
      if (gc_cand == '0) begin
         gc_cand = CW'(1);
      end else if (gc_cand > CW'(GROUPS)) begin
         gc_cand = CW'(GROUPS);
      end
      lgu_cand = LW'(csr_wdata[LGU_W-1:0]);
      if (lgu_cand == '0) begin
         lgu_cand = LW'(1);
      end else if (lgu_cand > LW'(UNITS_PER_GROUP)) begin
         lgu_cand = LW'(UNITS_PER_GROUP);
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      unit_ff  <= unit_in;
      word_ff  <= word_in;
      fbit_ff  <= fbit_in;
      fgrp_ff  <= fgrp_in;
      res_ff   <= res_in;
      if (state_ff == S_DONE && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ tb/testbench.sv @@
// Testbench for grouped_next_fit_bitmap_allocator_top: directed and random alloc/free
// traffic checked against an in-bench model of the grouped next-fit bitmap store.
// Depends on gnfa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module testbench;
   import gnfa_pkg::*;

   localparam int NGRP = 16;
   localparam int GSIZE = 256;
   localparam int LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   grouped_next_fit_bitmap_allocator_top u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   bit used_map [NGRP][GSIZE];
   int free_left [NGRP];
   int scan_pos [NGRP];
   int cur_grp;
   int grp_count;
   int last_units;
   rsp_payload_type expected_rsp [$];
   int errors = 0;
   int cycles = 0;
   bit stall_on = 1'b1;
   int stall_left = 0;

   function automatic int units_in(int g);
      if (g >= grp_count) return 0;
      if (g + 1 == grp_count) return last_units;
      return GSIZE;
   endfunction

   function automatic void clear_store();
      for (int g = 0; g < NGRP; g++) begin
         for (int b = 0; b < GSIZE; b++) used_map[g][b] = 1'b0;
         free_left[g] = units_in(g);
         scan_pos[g] = 0;
      end
      cur_grp = 0;
   endfunction

   function automatic bit take_from(int g, output int bit_no);
      bit_no = 0;
      if (free_left[g] == 0) return 1'b0;
      for (int b = scan_pos[g]; b < units_in(g); b++) begin
         if (!used_map[g][b]) begin
            used_map[g][b] = 1'b1;
            free_left[g]--;
            scan_pos[g] = b;
            bit_no = b;
            return 1'b1;
         end
      end
      scan_pos[g] = 0;
      return 1'b0;
   endfunction

   function automatic rsp_payload_type allocate_or_free(req_payload_type r);
      rsp_payload_type res;
      int start, c, b, g;
      bit found;
      res = '0;
      if (r.action == ACT_ALLOC) begin
         start = cur_grp;
         c = start;
         found = 1'b0;
         forever begin
            if (take_from(c, b)) begin
               found = 1'b1;
               break;
            end
            c = (c + 1) % grp_count;
            cur_grp = c;
            if (c == start) break;
         end
         if (!found) found = take_from(c, b);
         if (found) res.allocated_unit = UNIT_W'(c * GSIZE + b);
         else res.status = ST_NO_SPACE;
      end else begin
         g = r.unit_number / GSIZE;
         b = r.unit_number % GSIZE;
         if (g >= grp_count || b >= units_in(g)) begin
            res.status = ST_RANGE;
         end else if (used_map[g][b]) begin
            used_map[g][b] = 1'b0;
            free_left[g]++;
         end
      end
      return res;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected transfer status=%0d unit=%0d",
                   rsp_payload.status, rsp_payload.allocated_unit);
            errors++;
         end else begin
            rsp_payload_type e;
            e = expected_rsp.pop_front();
            if (rsp_payload.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_payload.status);
               errors++;
            end
            if (rsp_payload.allocated_unit !== e.allocated_unit) begin
               $error("allocated_unit expected %0d actual %0d",
                      e.allocated_unit, rsp_payload.allocated_unit);
               errors++;
            end
         end
      end
      if (!stall_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = gap_len();
         rsp_stall <= (stall_left != 0);
         if (stall_left > 0) stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_req(logic act, logic [UNIT_W-1:0] unit);
      req_payload_type r;
      int g;
      r.action = act;
      r.unit_number = unit;
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(allocate_or_free(r));
      g = stall_on ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_W-1:0] val);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_GROUP_COUNT) begin
         grp_count = val[4:0] < 1 ? 1 : (val[4:0] > NGRP ? NGRP : val[4:0]);
      end else begin
         last_units = val == 0 ? 1 : (val > GSIZE ? GSIZE : val);
      end
      clear_store();
   endtask

   task automatic test_directed();
      send_req(ACT_ALLOC, 12'hFFF);
      send_req(ACT_ALLOC, 12'h000);
      send_req(ACT_FREE, 12'd0);
      send_req(ACT_FREE, 12'd0);
      send_req(ACT_FREE, 12'd4095);
      send_req(ACT_FREE, 12'hAAA);
      send_req(ACT_FREE, 12'h555);
      send_req(ACT_ALLOC, 12'd0);
      write_csr(CSR_GROUP_COUNT, 9'd0);
      write_csr(CSR_LAST_UNITS, 9'd0);
      send_req(ACT_ALLOC, 12'd0);
      send_req(ACT_ALLOC, 12'd0);
      send_req(ACT_FREE, 12'd1);
      send_req(ACT_FREE, 12'd256);
      send_req(ACT_FREE, 12'd0);
      send_req(ACT_ALLOC, 12'd0);
      write_csr(CSR_LAST_UNITS, 9'h1FF);
      write_csr(CSR_GROUP_COUNT, 9'h1FF);
      send_req(ACT_FREE, 12'd4095);
      send_req(ACT_ALLOC, 12'd0);
   endtask

   task automatic test_fill_and_free();
      write_csr(CSR_GROUP_COUNT, 9'd3);
      write_csr(CSR_LAST_UNITS, 9'd5);
      for (int i = 0; i < 520; i++) send_req(ACT_ALLOC, 12'($urandom));
      for (int i = 0; i < 40; i++) send_req(ACT_FREE, 12'($urandom_range(0, 520)));
      for (int i = 0; i < 30; i++) send_req(ACT_ALLOC, 12'd0);
   endtask

   task automatic test_random(int n, int gc, int lu);
      write_csr(CSR_GROUP_COUNT, 9'(gc));
      write_csr(CSR_LAST_UNITS, 9'(lu));
      for (int i = 0; i < n; i++) begin
         int p;
         p = $urandom_range(0, 99);
         if (p < 55) send_req(ACT_ALLOC, 12'($urandom));
         else if (p < 90) send_req(ACT_FREE, 12'($urandom_range(0, gc * GSIZE - 1)));
         else send_req(ACT_FREE, 12'($urandom));
      end
   endtask

   task automatic test_no_idle();
      stall_on = 1'b0;
      test_random(100, 2, 17);
      drain();
      stall_on = 1'b1;
   endtask

   initial begin
      grp_count = NGRP;
      last_units = GSIZE;
      clear_store();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_free();
      test_random(250, 16, 256);
      test_random(200, 1, 40);
      test_random(150, 4, 1);
      test_random(150, $urandom_range(1, 16), $urandom_range(1, 256));
      test_no_idle();
      drain();
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
